### sv/lsal_pkg.sv
package lsal_pkg;

  localparam int NUM_LEVELS_DEF = 5;
  localparam int LVL_W = 3;
  localparam int QDEPTH = 2;
  localparam int QAW = $clog2(QDEPTH);
  localparam int DIV_NW = 56;
  localparam int DIV_DW = 30;
  localparam int DIV_CW = 6;

  localparam logic [1:0] ST_MEASURED = 2'd0;
  localparam logic [1:0] ST_UP = 2'd1;
  localparam logic [1:0] ST_DOWN = 2'd2;

  localparam logic [2:0] REG_RED = 3'd0;
  localparam logic [2:0] REG_GREEN = 3'd1;
  localparam logic [2:0] REG_BLUE = 3'd2;
  localparam logic [2:0] REG_TEMP_COEF = 3'd3;
  localparam logic [2:0] REG_TEMP_OFFSET = 3'd4;
  localparam logic [2:0] REG_GLASS = 3'd5;

  typedef struct packed {
    logic        measure;
    logic [1:0]  status;
    logic [2:0]  level;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] clear;
  } entry_t;

  typedef struct packed {
    logic [15:0] red_coef;
    logic [15:0] green_coef;
    logic [15:0] blue_coef;
    logic [15:0] temp_coef;
    logic [15:0] temp_offset;
    logic [15:0] glass;
  } cfg_t;

  typedef struct packed {
    logic                start;
    logic [DIV_NW-1:0]   num;
    logic [DIV_DW-1:0]   den;
    logic [DIV_CW-1:0]   nbits;
  } div_req_t;

  function automatic logic [15:0] lv_high(input logic [2:0] l);
    return (l == 3'd0) ? 16'd20000 : 16'd63000;
  endfunction

  function automatic logic [15:0] lv_low(input logic [2:0] l);
    logic [15:0] v;
    unique case (l)
      3'd0: v = 16'd0;
      3'd1: v = 16'd4990;
      3'd2: v = 16'd16790;
      default: v = 16'd15740;
    endcase
    return v;
  endfunction

  function automatic logic [8:0] lv_cycles(input logic [2:0] l);
    return (l == 3'd0) ? 9'd256 : 9'd64;
  endfunction

  function automatic logic [5:0] lv_gain(input logic [2:0] l);
    logic [5:0] v;
    unique case (l)
      3'd0, 3'd1: v = 6'd60;
      3'd2: v = 6'd16;
      3'd3: v = 6'd4;
      default: v = 6'd1;
    endcase
    return v;
  endfunction

  function automatic logic [DIV_DW-1:0] mlux_den(input logic [2:0] l);
    return DIV_DW'(576 * int'(lv_cycles(l)) * int'(lv_gain(l)));
  endfunction

  function automatic logic [DIV_DW-1:0] lux_den(input logic [2:0] l);
    return DIV_DW'(49152 * int'(lv_cycles(l)) * int'(lv_gain(l)));
  endfunction

  function automatic logic sat_flag(input logic [2:0] l, input logic [15:0] c);
    int cyc;
    int sat;
    int sat75;
    logic is_short;
    cyc = int'(lv_cycles(l));
    sat = (cyc > 63) ? 65535 : 1024 * cyc;
    is_short = (cyc * 24) < 1500;
    sat75 = is_short ? sat - sat / 4 : sat;
    return is_short && (int'(c) > sat75);
  endfunction

endpackage

### sv/lsal_div.sv
module lsal_div (
  input  logic                      clk,
  input  logic                      rst,
  input  lsal_pkg::div_req_t        req,
  output logic                      busy,
  output logic                      done,
  output logic [lsal_pkg::DIV_NW-1:0] quo
);
  import lsal_pkg::*;

  logic [DIV_DW-1:0] rem;
  logic [DIV_NW-1:0] sh;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW:0]   trial;
  logic              qbit;

  always_comb begin
    trial = {rem, sh[DIV_NW-1]};
    qbit = trial >= {1'b0, req.den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= !req.start && busy && (cnt == DIV_CW'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt <= req.nbits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sh <= req.num;
      quo <= '0;
      rem <= '0;
    end else if (busy) begin
      sh <= {sh[DIV_NW-2:0], 1'b0};
      quo <= {quo[DIV_NW-2:0], qbit};
      rem <= qbit ? DIV_DW'(trial - {1'b0, req.den}) : trial[DIV_DW-1:0];
    end
  end
endmodule

### sv/lsal_front.sv
module lsal_front #(
  parameter int NUM_LEVELS = lsal_pkg::NUM_LEVELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [63:0]         s_tdata,
  input  logic                full,
  output logic                push,
  output lsal_pkg::entry_t    push_entry
);
  import lsal_pkg::*;

  logic [2:0] range_level;
  logic [2:0] range_level_next;
  logic       measure_pending;
  logic [15:0] clear;
  logic       up;
  logic       down;

  assign s_tready = !full;
  assign push = s_tvalid && !full;
  assign clear = s_tdata[63:48];

  always_comb begin
    up = !measure_pending && (int'(range_level) + 1 < NUM_LEVELS)
         && (clear > lv_high(range_level));
    down = !measure_pending && (range_level != 3'd0) && (clear < lv_low(range_level));
    push_entry.red = s_tdata[15:0];
    push_entry.green = s_tdata[31:16];
    push_entry.blue = s_tdata[47:32];
    push_entry.clear = clear;
    priority if (up) begin
      range_level_next = range_level + 3'd1;
      push_entry.measure = 1'b0;
      push_entry.status = ST_UP;
    end else if (down) begin
      range_level_next = range_level - 3'd1;
      push_entry.measure = 1'b0;
      push_entry.status = ST_DOWN;
    end else begin
      range_level_next = range_level;
      push_entry.measure = 1'b1;
      push_entry.status = ST_MEASURED;
    end
    push_entry.level = range_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_level <= '0;
      measure_pending <= 1'b0;
    end else if (push) begin
      range_level <= range_level_next;
      measure_pending <= up || down;
    end
  end

`ifndef ASSERT_OFF
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    int'(range_level) < NUM_LEVELS) else $error("level out of range");
  a_pending_meas: assert property (@(posedge clk) disable iff (rst)
    (push && measure_pending) |-> push_entry.measure) else $error("pending sample ranged");
  a_step_sets: assert property (@(posedge clk) disable iff (rst)
    (push && !push_entry.measure) |=> measure_pending) else $error("pending not set");
`endif
endmodule

### sv/lsal_queue.sv
module lsal_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lsal_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output lsal_pkg::entry_t head
);
  import lsal_pkg::*;

  entry_t        mem [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QAW:0]   cnt;

  assign full = cnt == (QAW+1)'(QDEPTH);
  assign empty = cnt == '0;
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_entry;
  end
endmodule

### sv/lsal_back.sv
module lsal_back (
  input  logic             clk,
  input  logic             rst,
  input  lsal_pkg::cfg_t   cfg,
  input  lsal_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [183:0]     m_tdata,
  output logic [1:0]       m_tuser
);
  import lsal_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_COMP = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_SUM  = 9'b000001000,
    S_SLO  = 9'b000010000,
    S_SHI  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_WAIT = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {OP_RATIO, OP_CT, OP_MLUX, OP_LUX} op_t;

  state_t state;
  op_t    op;
  entry_t item;

  logic [16:0] ir;
  logic signed [17:0] rc, gc, bc, cc;
  logic        satf;
  logic signed [33:0] p0, p1, p2;
  logic signed [34:0] ctp;
  logic [35:0] sabs;
  logic        sneg;
  logic [34:0] mnum;
  logic [18:0] mfac;
  logic [36:0] plo, phi;
  logic [15:0] ratio;
  logic [15:0] ct;
  logic [19:0] mlux;
  logic [31:0] lux;

  logic [17:0] sum;
  logic [16:0] ir_next;
  logic signed [35:0] s_next;
  logic [34:0] ctabs;
  logic        ctneg;
  logic [17:0] rcabs;
  logic signed [36:0] ctq;
  logic signed [36:0] ctt;

  div_req_t          div_req;
  logic              div_busy;
  logic              div_done;
  logic [DIV_NW-1:0] quo;

  lsal_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .done (div_done),
    .quo  (quo)
  );

  assign pop = (state == S_IDLE) && !empty;

  always_comb begin
    sum = 18'(item.red) + 18'(item.green) + 18'(item.blue);
    ir_next = (sum > 18'(item.clear)) ? 17'((sum - 18'(item.clear)) >> 1) : 17'd0;
    s_next = 36'(p0) + 36'(p1) + 36'(p2);
    ctabs = ctp[34] ? 35'(-ctp) : 35'(ctp);
    ctneg = ctp[34] ^ rc[17];
    rcabs = rc[17] ? 18'(-rc) : 18'(rc);
    ctq = ctneg ? -$signed({2'b0, quo[34:0]}) : $signed({2'b0, quo[34:0]});
    ctt = ctq + $signed({21'b0, cfg.temp_offset});
    div_req.start = state == S_DIV;
    unique case (op)
      OP_RATIO: begin
        div_req.num = {ir, 16'b0, 23'b0};
        div_req.den = DIV_DW'(item.clear);
        div_req.nbits = DIV_CW'(33);
      end
      OP_CT: begin
        div_req.num = {ctabs, 21'b0};
        div_req.den = DIV_DW'(rcabs);
        div_req.nbits = DIV_CW'(35);
      end
      OP_MLUX: begin
        div_req.num = {mnum, 21'b0};
        div_req.den = mlux_den(item.level);
        div_req.nbits = DIV_CW'(35);
      end
      default: begin
        div_req.num = DIV_NW'(plo) + {phi, 18'b0} ;
        div_req.den = lux_den(item.level);
        div_req.nbits = DIV_CW'(56);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      op <= OP_RATIO;
    end else begin
      if (m_tvalid && m_tready && state != S_FIN) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (pop) state <= head.measure ? S_COMP : S_FIN;
        S_COMP: state <= S_MUL;
        S_MUL:  state <= S_SUM;
        S_SUM:  state <= S_SLO;
        S_SLO:  state <= S_SHI;
        S_SHI: begin
          op <= OP_RATIO;
          state <= S_DIV;
        end
        S_DIV:  state <= S_WAIT;
        S_WAIT: if (div_done) begin
          if (op == OP_LUX) begin
            state <= S_FIN;
          end else begin
            op <= op_t'(op + 2'd1);
            state <= S_DIV;
          end
        end
        S_FIN: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (pop) begin
        item <= head;
        ir <= '0;
        rc <= '0;
        gc <= '0;
        bc <= '0;
        cc <= '0;
        satf <= 1'b0;
        ratio <= '0;
        ct <= '0;
        mlux <= '0;
        lux <= '0;
      end
      S_COMP: begin
        ir <= ir_next;
        rc <= $signed({2'b0, item.red}) - $signed({1'b0, ir_next});
        gc <= $signed({2'b0, item.green}) - $signed({1'b0, ir_next});
        bc <= $signed({2'b0, item.blue}) - $signed({1'b0, ir_next});
        cc <= $signed({2'b0, item.clear}) - $signed({1'b0, ir_next});
        satf <= sat_flag(item.level, item.clear);
      end
      S_MUL: begin
        p0 <= $signed(cfg.red_coef) * rc;
        p1 <= $signed(cfg.green_coef) * gc;
        p2 <= $signed(cfg.blue_coef) * bc;
        ctp <= $signed({1'b0, cfg.temp_coef}) * bc;
      end
      S_SUM: begin
        sneg <= s_next[35];
        sabs <= s_next[35] ? 36'(-s_next) : 36'(s_next);
        mfac <= 19'(cfg.glass) * 19'd5;
        mnum <= 35'(cfg.glass) * 35'd327675;
      end
      S_SLO: plo <= 37'(sabs[17:0]) * 37'(mfac);
      S_SHI: phi <= 37'(sabs[35:18]) * 37'(mfac);
      S_WAIT: if (div_done) begin
        unique case (op)
          OP_RATIO: ratio <= (item.clear == '0 || quo > DIV_NW'(65535)) ? 16'hFFFF : quo[15:0];
          OP_CT: begin
            priority if (rc == '0) ct <= 16'hFFFF;
            else if (ctt < 0) ct <= '0;
            else if (ctt > 37'sd65535) ct <= 16'hFFFF;
            else ct <= ctt[15:0];
          end
          OP_MLUX: mlux <= (quo > DIV_NW'(1048575)) ? 20'hFFFFF : quo[19:0];
          default: begin
            priority if (!sneg && quo > DIV_NW'(32'h7FFFFFFF)) lux <= 32'h7FFFFFFF;
            else if (sneg && quo > DIV_NW'(32'h7FFFFFFF)) lux <= 32'h80000000;
            else if (sneg) lux <= -quo[31:0];
            else lux <= quo[31:0];
          end
        endcase
      end
      S_FIN: if (!m_tvalid || m_tready) begin
        m_tuser <= item.status;
        m_tdata <= {7'b0, mlux, ct, lux, satf, ratio, cc, bc, gc, rc, ir, item.level};
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy) else $error("divider restarted while busy");
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !div_busy) else $error("divider busy while idle");
  a_step_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_MEASURED) |-> (m_tdata[183:3] == '0))
    else $error("step result carries data");
`endif
endmodule

### sv/light_sensor_autorange_lux.sv
// Auto-ranging RGBC lux engine. Each sample on s_* either moves the gain/time level
// (result with status up or down, the new level and all other data zero; the next
// sample is measured unchecked) or is measured into IR, compensated channels, IR
// ratio, saturation, lux, color temperature and maximum lux. A measured sample's
// time is set by one shared 1-bit-per-cycle divider that runs four divisions in
// turn (33, 35, 35 and 56 steps). A two-entry queue sits between the ranging front
// end and the arithmetic back end, so the front accepts samples while the back
// works. cfg_* writes are always ready; indexes past the last register are
// ignored.
module light_sensor_autorange_lux #(
  parameter int NUM_LEVELS = lsal_pkg::NUM_LEVELS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // red_count, green_count, blue_count, clear_count
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [183:0] m_tdata,   // level, infrared, red_comp, green_comp, blue_comp,
                                  // clear_comp, ir_ratio, saturated, lux, color_temp,
                                  // max_lux
  output logic [1:0]   m_tuser,   // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import lsal_pkg::*;

  cfg_t   cfg;
  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_coef <= 16'd557;
      cfg.green_coef <= 16'd4096;
      cfg.blue_coef <= 16'hF8E5;
      cfg.temp_coef <= 16'd3810;
      cfg.temp_offset <= 16'd1391;
      cfg.glass <= 16'd4960;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RED:         cfg.red_coef <= cfg_data;
        REG_GREEN:       cfg.green_coef <= cfg_data;
        REG_BLUE:        cfg.blue_coef <= cfg_data;
        REG_TEMP_COEF:   cfg.temp_coef <= cfg_data;
        REG_TEMP_OFFSET: cfg.temp_offset <= cfg_data;
        REG_GLASS:       cfg.glass <= cfg_data;
        default: ;
      endcase
    end
  end

  lsal_front #(.NUM_LEVELS(NUM_LEVELS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  lsal_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .head       (head)
  );

  lsal_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );
endmodule

### tb/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lsal_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int LONG_STALL = 400;

  typedef struct packed {
    logic [15:0] clear;
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } sample_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  level;
    logic [16:0] infrared;
    logic [17:0] red_comp;
    logic [17:0] green_comp;
    logic [17:0] blue_comp;
    logic [17:0] clear_comp;
    logic [15:0] ir_ratio;
    logic        saturated;
    logic [31:0] lux;
    logic [15:0] color_temp;
    logic [19:0] max_lux;
  } lux_result_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [63:0]  s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [183:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [15:0]  cfg_data;

  light_sensor_autorange_lux u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sample_t     sample_q[$];
  lux_result_t expected_q[$];

  // predictor state
  logic [2:0]  cur_level;
  logic        measure_due;
  logic [15:0] coef_red, coef_green, coef_blue, temp_coef, temp_off, glass;

  int  mismatches;
  int  tx_gap;
  int  rx_gap;
  int  stall_cnt;
  int  idle_cycles;
  bit  quiet;
  bit  stall_req;
  bit  stall_done;

  function automatic longint lvl_cycles(input logic [2:0] l);
    return (l == 3'd0) ? 256 : 64;
  endfunction

  function automatic longint lvl_gain(input logic [2:0] l);
    case (l)
      3'd0, 3'd1: return 60;
      3'd2: return 16;
      3'd3: return 4;
      default: return 1;
    endcase
  endfunction

  function automatic longint lvl_low(input logic [2:0] l);
    case (l)
      3'd0: return 0;
      3'd1: return 4990;
      3'd2: return 16790;
      default: return 15740;
    endcase
  endfunction

  function automatic longint lvl_high(input logic [2:0] l);
    return (l == 3'd0) ? 20000 : 63000;
  endfunction

  function automatic lux_result_t compute_lux(input sample_t smp);
    lux_result_t res;
    longint r, g, b, c, ir, rc, gc, bc, cc, ratio, cyc, gain, sat, sat75;
    longint mlux, s, lux, ct;
    logic [2:0] lvl;
    bit is_short;
    res = '0;
    r = smp.red;
    g = smp.green;
    b = smp.blue;
    c = smp.clear;
    lvl = cur_level;
    if (!measure_due) begin
      if (int'(lvl) + 1 < NUM_LEVELS_DEF && c > lvl_high(lvl)) begin
        cur_level = lvl + 3'd1;
        measure_due = 1'b1;
        res.status = ST_UP;
        res.level = cur_level;
        return res;
      end
      if (lvl > 3'd0 && c < lvl_low(lvl)) begin
        cur_level = lvl - 3'd1;
        measure_due = 1'b1;
        res.status = ST_DOWN;
        res.level = cur_level;
        return res;
      end
    end
    measure_due = 1'b0;
    ir = (r + g + b > c) ? (r + g + b - c) >> 1 : 0;
    rc = r - ir;
    gc = g - ir;
    bc = b - ir;
    cc = c - ir;
    if (c == 0) ratio = 65535;
    else begin
      ratio = (ir <<< 16) / c;
      if (ratio > 65535) ratio = 65535;
    end
    cyc = lvl_cycles(lvl);
    gain = lvl_gain(lvl);
    sat = (cyc > 63) ? 65535 : 1024 * cyc;
    is_short = cyc * 24 < 1500;
    sat75 = is_short ? sat - sat / 4 : sat;
    mlux = (65535 * 5 * longint'(glass)) / (576 * cyc * gain);
    if (mlux > 1048575) mlux = 1048575;
    s = longint'($signed(coef_red)) * rc + longint'($signed(coef_green)) * gc
      + longint'($signed(coef_blue)) * bc;
    lux = (s * 5 * longint'(glass)) / (49152 * cyc * gain);
    if (lux > 64'sd2147483647) lux = 64'sd2147483647;
    if (lux < -64'sd2147483648) lux = -64'sd2147483648;
    if (rc == 0) ct = 65535;
    else begin
      ct = (longint'(temp_coef) * bc) / rc + longint'(temp_off);
      if (ct > 65535) ct = 65535;
      if (ct < 0) ct = 0;
    end
    res.status = ST_MEASURED;
    res.level = lvl;
    res.infrared = ir[16:0];
    res.red_comp = rc[17:0];
    res.green_comp = gc[17:0];
    res.blue_comp = bc[17:0];
    res.clear_comp = cc[17:0];
    res.ir_ratio = ratio[15:0];
    res.saturated = is_short && c > sat75;
    res.lux = lux[31:0];
    res.color_temp = ct[15:0];
    res.max_lux = mlux[19:0];
    return res;
  endfunction

  function automatic sample_t random_sample();
    sample_t smp;
    int unsigned pick;
    smp.red = 16'($urandom);
    smp.green = 16'($urandom);
    smp.blue = 16'($urandom);
    pick = $urandom_range(0, 11);
    case (pick)
      0: smp.clear = 16'($urandom_range(19999, 20001));
      1: smp.clear = 16'($urandom_range(62999, 63001));
      2: smp.clear = 16'($urandom_range(4989, 4991));
      3: smp.clear = 16'($urandom_range(16789, 16791));
      4: smp.clear = 16'($urandom_range(15739, 15741));
      5: smp.clear = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
      6: smp.clear = 16'($urandom_range(0, 4000));
      7: smp.clear = 16'($urandom_range(63001, 65535));
      default: smp.clear = 16'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: begin
        smp.red = 16'($urandom_range(0, 500));
        smp.green = 16'($urandom_range(0, 500));
        smp.blue = 16'($urandom_range(0, 500));
      end
      1: begin
        // red equal to the IR estimate
        smp.green = 16'($urandom_range(0, 30000));
        smp.blue = 16'($urandom_range(0, 30000));
        smp.clear = 16'($urandom_range(0, int'(smp.green) + int'(smp.blue)));
        smp.red = smp.green + smp.blue - smp.clear;
      end
      default: ;
    endcase
    return smp;
  endfunction

  function automatic lux_result_t unpack_result(input logic [183:0] d, input logic [1:0] u);
    lux_result_t res;
    res.status = u;
    res.level = d[2:0];
    res.infrared = d[19:3];
    res.red_comp = d[37:20];
    res.green_comp = d[55:38];
    res.blue_comp = d[73:56];
    res.clear_comp = d[91:74];
    res.ir_ratio = d[107:92];
    res.saturated = d[108];
    res.lux = d[140:109];
    res.color_temp = d[156:141];
    res.max_lux = d[176:157];
    return res;
  endfunction

  task automatic add_sample(input logic [15:0] r, input logic [15:0] g,
                            input logic [15:0] b, input logic [15:0] c);
    sample_t smp;
    smp.red = r;
    smp.green = g;
    smp.blue = b;
    smp.clear = c;
    sample_q.push_back(smp);
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || s_tvalid || expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RED: coef_red = val;
      REG_GREEN: coef_green = val;
      REG_BLUE: coef_blue = val;
      REG_TEMP_COEF: temp_coef = val;
      REG_TEMP_OFFSET: temp_off = val;
      REG_GLASS: glass = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] vr, input logic [15:0] vg, input logic [15:0] vb,
                           input logic [15:0] vt, input logic [15:0] vo, input logic [15:0] vgl);
    write_reg(REG_RED, vr);
    write_reg(REG_GREEN, vg);
    write_reg(REG_BLUE, vb);
    write_reg(REG_TEMP_COEF, vt);
    write_reg(REG_TEMP_OFFSET, vo);
    write_reg(REG_GLASS, vgl);
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    logic    nv;
    sample_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      nv = s_tvalid;
      if (s_tvalid && s_tready) begin
        expected_q.push_back(compute_lux(sample_t'(s_tdata)));
        nv = 1'b0;
      end
      if (!nv) begin
        if (tx_gap > 0) tx_gap--;
        else if (!quiet && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(0, 4);
        else if (sample_q.size() != 0) begin
          nxt = sample_q.pop_front();
          nv = 1'b1;
          s_tdata <= {nxt.clear, nxt.blue, nxt.green, nxt.red};
        end
      end
      s_tvalid <= nv;
    end
  end

  // monitor
  always @(posedge clk) begin
    lux_result_t got, want;
    logic        rdy;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = unpack_result(m_tdata, m_tuser);
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch:\n  expected %p\n  actual   %p", want, got);
          end
        end
      end
      if (stall_req && !stall_done) begin
        rdy = 1'b0;
        stall_cnt++;
        if (stall_cnt >= LONG_STALL) stall_done = 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        rdy = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        rx_gap = $urandom_range(0, 4);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_tready <= rdy;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    tx_gap = 0;
    rx_gap = 0;
    stall_cnt = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    stall_req = 1'b0;
    stall_done = 1'b0;
    cur_level = '0;
    measure_due = 1'b0;
    coef_red = 16'd557;
    coef_green = 16'd4096;
    coef_blue = 16'hF8E5;
    temp_coef = 16'd3810;
    temp_off = 16'd1391;
    glass = 16'd4960;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero sample, ranging walk over every level, special cases
    add_sample(16'd0, 16'd0, 16'd0, 16'd0);
    add_sample(16'd100, 16'd200, 16'd0, 16'd100);
    add_sample(16'd1000, 16'd1000, 16'd0, 16'd500);
    add_sample(16'd0, 16'd0, 16'd0, 16'd20000);
    add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_sample(16'd0, 16'd0, 16'd0, 16'd63000);
    repeat (3) begin
      add_sample(16'h1234, 16'h5678, 16'h9ABC, 16'd63001);
      add_sample(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
    end
    add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_sample(16'd10, 16'd20, 16'd30, 16'd15739);
    add_sample(16'd0, 16'hFFFF, 16'd0, 16'd0);
    add_sample(16'd5, 16'd5, 16'd5, 16'd16789);
    add_sample(16'd5, 16'd5, 16'd5, 16'd4990);
    add_sample(16'd9, 16'd9, 16'd9, 16'd4989);
    add_sample(16'hAAAA, 16'h5555, 16'hFFFF, 16'd0);
    add_sample(16'd1, 16'd1, 16'd1, 16'd1);
    drain();

    // extreme coefficients, zero glass factor
    write_all(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd0, 16'd0);
    repeat (60) sample_q.push_back(random_sample());
    drain();

    write_all(16'h7FFF, 16'h8000, 16'h7FFF, 16'd0, 16'hFFFF, 16'hFFFF);
    stall_req = 1'b1;
    repeat (110) sample_q.push_back(random_sample());
    drain();

    write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
    repeat (110) sample_q.push_back(random_sample());
    drain();

    write_all(16'd557, 16'd4096, 16'hF8E5, 16'd3810, 16'd1391, 16'd4960);
    repeat (90) sample_q.push_back(random_sample());
    drain();

    quiet = 1'b1;
    repeat (60) sample_q.push_back(random_sample());
    drain();
    repeat (200) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
